// ===== design/slcr_pkg.sv =====
// Package: shared types and constants for the stepper link command/reply engine.
`timescale 1ns / 1ps
`default_nettype none
package slcr_pkg;

   // Item selector on the request side
   localparam logic CMD_ISSUE = 1'b0;
   localparam logic CMD_RECV  = 1'b1;

   // Result kind
   localparam logic KIND_TX    = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   // Command opcodes
   localparam logic [3:0] OP_CALIB   = 4'd0;
   localparam logic [3:0] OP_ZERO    = 4'd1;
   localparam logic [3:0] OP_UNSTALL = 4'd2;
   localparam logic [3:0] OP_RDENC   = 4'd3;
   localparam logic [3:0] OP_RDPULSE = 4'd4;
   localparam logic [3:0] OP_RDPOS   = 4'd5;
   localparam logic [3:0] OP_RDERR   = 4'd6;
   localparam logic [3:0] OP_ENABLE  = 4'd7;
   localparam logic [3:0] OP_SPEED   = 4'd8;
   localparam logic [3:0] OP_POS     = 4'd9;

   // Function bytes
   localparam logic [7:0] FN_CALIB    = 8'h06;
   localparam logic [7:0] SUB_CALIB   = 8'h45;
   localparam logic [7:0] FN_ZERO     = 8'h0A;
   localparam logic [7:0] SUB_ZERO    = 8'h6D;
   localparam logic [7:0] FN_UNSTALL  = 8'h0E;
   localparam logic [7:0] SUB_UNSTALL = 8'h52;
   localparam logic [7:0] FN_RDENC    = 8'h30;
   localparam logic [7:0] FN_RDPULSE  = 8'h33;
   localparam logic [7:0] FN_RDPOS    = 8'h36;
   localparam logic [7:0] FN_RDERR    = 8'h39;
   localparam logic [7:0] FN_ENABLE   = 8'hF3;
   localparam logic [7:0] FN_SPEED    = 8'hF6;
   localparam logic [7:0] FN_POS      = 8'hFD;

   // Acknowledge status codes
   localparam logic [7:0] ACK_OK   = 8'h02;
   localparam logic [7:0] ACK_ERR  = 8'hEE;
   localparam logic [7:0] ACK_DONE = 8'h9F;

   localparam logic [11:0] SPEED_MAX = 12'h4FF;

   localparam int FRAME_MAX = 9;
   localparam int RX_DEPTH  = 6;

   // Built command frame
   typedef struct packed {
      logic [FRAME_MAX-1:0][7:0] bytes;
      logic [3:0]                len;      // total bytes, id through check byte
      logic                      known;    // opcode is one of the ten commands
      logic [2:0]                exp_len;  // reply length this command expects
   } frame_type;

   // Issue event seen by the reply matcher
   typedef struct packed {
      logic       valid;
      logic [3:0] op;
      logic [7:0] id;
      logic [2:0] exp_len;
   } issue_type;

endpackage
`default_nettype wire

// ===== design/slcr_frame_build.sv =====
// Frame builder: maps one issue item onto its command frame bytes.
`timescale 1ns / 1ps
`default_nettype none
module slcr_frame_build (
   input  wire logic [3:0]       op,
   input  wire logic [7:0]       dev_id,
   input  wire logic             direction,
   input  wire logic [15:0]      speed,
   input  wire logic [7:0]       accel,
   input  wire logic [23:0]      pulses,
   input  wire logic             enable_flag,
   input  wire logic [7:0]       check_byte,
   output slcr_pkg::frame_type   frame
);
   import slcr_pkg::*;

   logic [11:0] spd_clamp;
   logic [7:0]  dir_byte;

   // Saturate speed, then form the direction/speed-high byte
   always_comb begin
      if (speed > {4'd0, SPEED_MAX}) begin
         spd_clamp = SPEED_MAX;
      end else begin
         spd_clamp = speed[11:0];
      end
      dir_byte = {3'd0, direction, spd_clamp[11:8]};
   end

   // Frame contents per opcode
   always_comb begin
      frame          = '0;
      frame.bytes[0] = dev_id;
      frame.known    = 1'b1;
      case (op)
         OP_CALIB: begin
            frame.bytes[1] = FN_CALIB;
            frame.bytes[2] = SUB_CALIB;
            frame.bytes[3] = check_byte;
            frame.len      = 4'd4;
            frame.exp_len  = 3'd3;
         end
         OP_ZERO: begin
            frame.bytes[1] = FN_ZERO;
            frame.bytes[2] = SUB_ZERO;
            frame.bytes[3] = check_byte;
            frame.len      = 4'd4;
            frame.exp_len  = 3'd3;
         end
         OP_UNSTALL: begin
            frame.bytes[1] = FN_UNSTALL;
            frame.bytes[2] = SUB_UNSTALL;
            frame.bytes[3] = check_byte;
            frame.len      = 4'd4;
            frame.exp_len  = 3'd3;
         end
         OP_RDENC: begin
            frame.bytes[1] = FN_RDENC;
            frame.bytes[2] = check_byte;
            frame.len      = 4'd3;
            frame.exp_len  = 3'd4;
         end
         OP_RDPULSE: begin
            frame.bytes[1] = FN_RDPULSE;
            frame.bytes[2] = check_byte;
            frame.len      = 4'd3;
            frame.exp_len  = 3'd6;
         end
         OP_RDPOS: begin
            frame.bytes[1] = FN_RDPOS;
            frame.bytes[2] = check_byte;
            frame.len      = 4'd3;
            frame.exp_len  = 3'd6;
         end
         OP_RDERR: begin
            frame.bytes[1] = FN_RDERR;
            frame.bytes[2] = check_byte;
            frame.len      = 4'd3;
            frame.exp_len  = 3'd4;
         end
         OP_ENABLE: begin
            frame.bytes[1] = FN_ENABLE;
            frame.bytes[2] = {7'd0, enable_flag};
            frame.bytes[3] = check_byte;
            frame.len      = 4'd4;
            frame.exp_len  = 3'd3;
         end
         OP_SPEED: begin
            frame.bytes[1] = FN_SPEED;
            frame.bytes[2] = dir_byte;
            frame.bytes[3] = spd_clamp[7:0];
            frame.bytes[4] = accel;
            frame.bytes[5] = check_byte;
            frame.len      = 4'd6;
            frame.exp_len  = 3'd3;
         end
         OP_POS: begin
            frame.bytes[1] = FN_POS;
            frame.bytes[2] = dir_byte;
            frame.bytes[3] = spd_clamp[7:0];
            frame.bytes[4] = accel;
            frame.bytes[5] = pulses[23:16];
            frame.bytes[6] = pulses[15:8];
            frame.bytes[7] = pulses[7:0];
            frame.bytes[8] = check_byte;
            frame.len      = 4'd9;
            frame.exp_len  = 3'd3;
         end
         default: begin
            frame.known = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== design/slcr_reply_match.sv =====
// Reply matcher: collects received bytes and decodes replies to the last command.
`timescale 1ns / 1ps
`default_nettype none
module slcr_reply_match (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire slcr_pkg::issue_type issue,
   input  wire logic                rx_valid,
   input  wire logic [7:0]          rx_byte,
   input  wire logic [7:0]          check_byte,
   output logic                     hit,
   output logic [31:0]              value
);
   import slcr_pkg::*;

   logic [RX_DEPTH-1:0][7:0] rx_store_ff;
   logic [RX_DEPTH-1:0][7:0] rx_store_in;
   logic [2:0]               rx_count_ff, rx_count_in;
   logic [2:0]               expect_len_ff, expect_len_in;
   logic [3:0]               pending_op_ff, pending_op_in;
   logic [7:0]               target_id_ff, target_id_in;
   logic                     armed_ff, armed_in;
   logic                     take;
   logic [2:0]               cnt_next;
   logic                     full;
   logic                     is_short, is_long;

   // Collector update and reply decode
   always_comb begin
      rx_store_in   = rx_store_ff;
      rx_count_in   = rx_count_ff;
      expect_len_in = expect_len_ff;
      pending_op_in = pending_op_ff;
      target_id_in  = target_id_ff;
      armed_in      = armed_ff;
      hit           = 1'b0;
      value         = '0;
      full          = 1'b0;
      is_short      = (pending_op_ff == OP_RDENC) || (pending_op_ff == OP_RDERR);
      is_long       = (pending_op_ff == OP_RDPULSE) || (pending_op_ff == OP_RDPOS);
      take          = rx_valid && armed_ff && (expect_len_ff != 3'd0);
      cnt_next      = rx_count_ff + 3'd1;

      if (issue.valid) begin
         // new command: restart collection and arm for its reply
         rx_count_in   = '0;
         expect_len_in = issue.exp_len;
         pending_op_in = issue.op;
         target_id_in  = issue.id;
         armed_in      = 1'b1;
      end else if (take) begin
         for (int i = 0; i < RX_DEPTH; i++) begin
            if (rx_count_ff == 3'(i)) begin
               rx_store_in[i] = rx_byte;
            end
         end
         rx_count_in = cnt_next;
         full        = (cnt_next == expect_len_ff);
         if (full) begin
            rx_count_in = '0;
            if (rx_store_in[0] == target_id_ff) begin
               if (is_short && cnt_next == 3'd4) begin
                  hit   = 1'b1;
                  value = {16'd0, rx_store_in[1], rx_store_in[2]};
               end
               if (is_long && cnt_next == 3'd6) begin
                  hit   = 1'b1;
                  value = {rx_store_in[1], rx_store_in[2], rx_store_in[3], rx_store_in[4]};
               end
               if (cnt_next == 3'd3 && rx_store_in[2] == check_byte &&
                   (rx_store_in[1] == ACK_OK || rx_store_in[1] == ACK_ERR ||
                    rx_store_in[1] == ACK_DONE)) begin
                  hit   = 1'b1;
                  value = {24'd0, rx_store_in[1]};
               end
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_count_ff   <= '0;
         expect_len_ff <= '0;
         pending_op_ff <= '0;
         target_id_ff  <= '0;
         armed_ff      <= 1'b0;
      end else begin
         rx_count_ff   <= rx_count_in;
         expect_len_ff <= expect_len_in;
         pending_op_ff <= pending_op_in;
         target_id_ff  <= target_id_in;
         armed_ff      <= armed_in;
      end
   end

   // Byte store, no reset
   always_ff @(posedge clock) begin
      rx_store_ff <= rx_store_in;
   end

   // Collector never runs past the expected reply length
   assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (rx_count_ff < expect_len_ff))
      else $error("rx count reached expected length without clearing");

   // A reply only comes out on a byte that completes the collection
   assert property (@(posedge clock) disable iff (reset)
      hit |-> (take && full))
      else $error("reply decoded outside a completed collection");

   // Issuing clears the collector on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      issue.valid |=> (rx_count_ff == 3'd0) && armed_ff)
      else $error("issue did not restart the collector");

endmodule
`default_nettype wire

// ===== design/slcr_tx_seq.sv =====
// Transmit sequencer: holds one frame or reply and feeds the result register.
`timescale 1ns / 1ps
`default_nettype none
module slcr_tx_seq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load_frame,
   input  wire slcr_pkg::frame_type frame,
   input  wire logic                load_reply,
   input  wire logic [31:0]         reply_value,
   output logic                     free,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_kind,
   output logic [7:0]               rsp_byte,
   output logic                     rsp_last,
   output logic [31:0]              rsp_value
);
   import slcr_pkg::*;

   // Work register: one frame or one reply being drained
   logic                      w_valid_ff, w_valid_in;
   logic [FRAME_MAX-1:0][7:0] w_bytes_ff, w_bytes_in;
   logic [3:0]                w_len_ff, w_len_in;
   logic [3:0]                w_idx_ff, w_idx_in;
   logic                      w_kind_ff, w_kind_in;
   logic [31:0]               w_value_ff, w_value_in;

   // Result register
   logic                      o_valid_ff, o_valid_in;
   logic                      o_kind_ff, o_kind_in;
   logic [7:0]                o_byte_ff, o_byte_in;
   logic                      o_last_ff, o_last_in;
   logic [31:0]               o_value_ff, o_value_in;

   logic                      out_load;
   logic                      w_last;

   always_comb begin
      out_load = w_valid_ff && (!o_valid_ff || rsp_ready);
      w_last   = (w_idx_ff == w_len_ff - 4'd1);
      free     = !w_valid_ff || (out_load && w_last);

      // work register: step through bytes, reload on a new item
      w_valid_in = w_valid_ff;
      w_bytes_in = w_bytes_ff;
      w_len_in   = w_len_ff;
      w_idx_in   = w_idx_ff;
      w_kind_in  = w_kind_ff;
      w_value_in = w_value_ff;
      if (out_load) begin
         w_idx_in = w_idx_ff + 4'd1;
         if (w_last) begin
            w_valid_in = 1'b0;
         end
      end
      if (load_frame) begin
         w_valid_in = 1'b1;
         w_bytes_in = frame.bytes;
         w_len_in   = frame.len;
         w_idx_in   = '0;
         w_kind_in  = KIND_TX;
         w_value_in = '0;
      end else if (load_reply) begin
         w_valid_in = 1'b1;
         w_bytes_in = '0;
         w_len_in   = 4'd1;
         w_idx_in   = '0;
         w_kind_in  = KIND_REPLY;
         w_value_in = reply_value;
      end

      // result register
      o_valid_in = o_valid_ff && !rsp_ready;
      o_kind_in  = o_kind_ff;
      o_byte_in  = o_byte_ff;
      o_last_in  = o_last_ff;
      o_value_in = o_value_ff;
      if (out_load) begin
         o_valid_in = 1'b1;
         o_kind_in  = w_kind_ff;
         o_byte_in  = w_bytes_ff[w_idx_ff];
         o_last_in  = w_last;
         o_value_in = w_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
         w_idx_ff   <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         w_valid_ff <= w_valid_in;
         w_idx_ff   <= w_idx_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_bytes_ff <= w_bytes_in;
      w_len_ff   <= w_len_in;
      w_kind_ff  <= w_kind_in;
      w_value_ff <= w_value_in;
      o_kind_ff  <= o_kind_in;
      o_byte_ff  <= o_byte_in;
      o_last_ff  <= o_last_in;
      o_value_ff <= o_value_in;
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_kind  = o_kind_ff;
   assign rsp_byte  = o_byte_ff;
   assign rsp_last  = o_last_ff;
   assign rsp_value = o_value_ff;

   // A new frame or reply only lands in a free work register
   assert property (@(posedge clock) disable iff (reset)
      (load_frame || load_reply) |-> free)
      else $error("work register overwritten while draining");

   // Frame and reply never load together
   assert property (@(posedge clock) disable iff (reset)
      !(load_frame && load_reply))
      else $error("frame and reply loaded in one cycle");

   // Byte index stays inside the held frame
   assert property (@(posedge clock) disable iff (reset)
      w_valid_ff |-> (w_idx_ff < w_len_ff))
      else $error("byte index past end of frame");

   // A reply is always a single-item, last-marked result
   assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && o_kind_ff == KIND_REPLY) |-> o_last_ff)
      else $error("reply result without last mark");

endmodule
`default_nettype wire

// ===== design/stepper_link_command_reply_engine.sv =====
// Top level: host-side command framer and reply decoder for a stepper driver link.
//
// Request channel (req_*): one item per handshake. req_tuser = 0 issues a command
// frame built from the fields in req_tdata; req_tuser = 1 hands in one byte
// received from the driver. Result channel (rsp_*): rsp_tuser = 0 carries one
// frame byte to transmit, rsp_tuser = 1 a decoded reply value; rsp_tlast marks
// the final byte of a frame (always the check byte) and every reply.
// csr_we/csr_wdata write the check byte; write only while the block is idle.
//
// The first result of an item passes through the work register, then the
// result register.
// Throughput: one byte per cycle moves from the work register to the result
// register unless it is stalled; the next item is taken in the cycle its last
// byte moves. Items without a result (dropped bytes, partial replies, unknown
// opcodes) are taken every cycle while the work register is free.
// Reset clears the sequencer, the result register and the reply matcher
// (nothing armed, check byte back to 0x6B). When the receiver holds rsp_tready
// low the result register holds, then the work register, then req_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module stepper_link_command_reply_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // {op[3:0], dev_id[11:4], direction[12], speed[28:13], accel[36:29],
   //  pulses[60:37], enable_flag[61], rx_byte[69:62], pad[71:70]}
   input  wire logic [71:0] req_tdata,
   // cmd
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // {tx_byte[7:0], reply_value[39:8]}
   output logic [39:0]      rsp_tdata,
   // out_kind
   output logic             rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata
);
   import slcr_pkg::*;

   logic [7:0]  check_ff, check_in;
   logic        accept;
   frame_type   frame;
   issue_type   issue;
   logic        hit;
   logic [31:0] value;
   logic        free;
   logic        rsp_kind;
   logic [7:0]  rsp_byte;
   logic [31:0] rsp_value;

   // Check byte register
   always_comb begin
      check_in = csr_we ? csr_wdata : check_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_ff <= 8'd107;
      end else begin
         check_ff <= check_in;
      end
   end

   assign req_tready = free;
   assign accept     = req_tvalid && req_tready;

   slcr_frame_build u_build (
      .op          (req_tdata[3:0]),
      .dev_id      (req_tdata[11:4]),
      .direction   (req_tdata[12]),
      .speed       (req_tdata[28:13]),
      .accel       (req_tdata[36:29]),
      .pulses      (req_tdata[60:37]),
      .enable_flag (req_tdata[61]),
      .check_byte  (check_ff),
      .frame       (frame)
   );

   // Issue event for the matcher
   always_comb begin
      issue.valid   = accept && (req_tuser == CMD_ISSUE) && frame.known;
      issue.op      = req_tdata[3:0];
      issue.id      = req_tdata[11:4];
      issue.exp_len = frame.exp_len;
   end

   slcr_reply_match u_match (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .rx_valid   (accept && (req_tuser == CMD_RECV)),
      .rx_byte    (req_tdata[69:62]),
      .check_byte (check_ff),
      .hit        (hit),
      .value      (value)
   );

   slcr_tx_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .load_frame  (issue.valid),
      .frame       (frame),
      .load_reply  (hit),
      .reply_value (value),
      .free        (free),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_kind    (rsp_kind),
      .rsp_byte    (rsp_byte),
      .rsp_last    (rsp_tlast),
      .rsp_value   (rsp_value)
   );

   assign rsp_tuser = rsp_kind;
   assign rsp_tdata = {rsp_value, rsp_byte};

endmodule
`default_nettype wire
